// ===== sv/pimd_pkg.sv =====
`default_nettype none

package pimd_pkg;

    localparam int COUNTER_WIDTH_DEF = 16;
    localparam int CAPTURE_WIDTH     = 16;
    localparam int TICK_WIDTH        = 16;
    localparam int TIME_WIDTH        = 32;
    localparam int DUTY_FRAC         = 16;
    localparam int DUTY_WIDTH        = DUTY_FRAC + 1;
    localparam int OUT_DATA_WIDTH    = ((2 * TIME_WIDTH + DUTY_WIDTH + 7) / 8) * 8;

    localparam logic [TICK_WIDTH-1:0] TICK_LENGTH_RESET = TICK_WIDTH'(1);
    localparam logic [DUTY_WIDTH-1:0] DUTY_ONE          = DUTY_WIDTH'(1) << DUTY_FRAC;

    localparam logic OP_PERIOD_EDGE = 1'b0;
    localparam logic OP_PULSE_EDGE  = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

`default_nettype wire

// ===== sv/pimd_mul.sv =====
`default_nettype none

module pimd_mul import pimd_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [COUNTER_WIDTH:0]   ticks,
    input  wire logic [TICK_WIDTH-1:0]    tick_length,
    output unit_status_t                  status,
    output logic [TIME_WIDTH-1:0]         scaled_time
);

    localparam int TW    = COUNTER_WIDTH + 1;
    localparam int PXW   = (TW + TICK_WIDTH + 1 > TIME_WIDTH + 1) ?
                           (TW + TICK_WIDTH + 1) : (TIME_WIDTH + 1);
    localparam int UW    = PXW - TICK_WIDTH;
    localparam int CNT_W = $clog2(TICK_WIDTH);

    logic [PXW-1:0]   prod_reg, prod_next;
    logic [TW-1:0]    mcand_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [UW-1:0]    sum;
    logic             over;

    always_comb
    begin
        sum       = prod_reg[PXW-1:TICK_WIDTH] + (prod_reg[0] ? UW'(mcand_reg) : UW'(0));
        prod_next = prod_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            prod_next = PXW'(tick_length);
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            prod_next = {1'b0, sum, prod_reg[TICK_WIDTH-1:1]};
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(TICK_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (start)
        begin
            mcand_reg <= ticks;
        end
    end

    // A product beyond the time width saturates to all ones.
    assign over        = |prod_reg[PXW-1:TIME_WIDTH];
    assign scaled_time = over ? {TIME_WIDTH{1'b1}} : prod_reg[TIME_WIDTH-1:0];
    assign status      = '{busy: busy_reg, done: done_reg};

endmodule

`default_nettype wire

// ===== sv/pimd_div.sv =====
`default_nettype none

module pimd_div import pimd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [TIME_WIDTH-1:0]  dividend,
    input  wire logic [TIME_WIDTH-1:0]  divisor,
    output unit_status_t                status,
    output logic [DUTY_WIDTH-1:0]       quotient
);

    localparam int CNT_W = $clog2(DUTY_FRAC);

    logic [TIME_WIDTH:0]    rem_reg, rem_next;
    logic [TIME_WIDTH-1:0]  dsr_reg, dsr_next;
    logic [DUTY_WIDTH-1:0]  quot_reg, quot_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [TIME_WIDTH:0]    rem_shift;
    logic                   fits;

    always_comb
    begin
        rem_shift = {rem_reg[TIME_WIDTH-1:0], 1'b0};
        fits      = rem_shift >= {1'b0, dsr_reg};
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dsr_next = divisor;
            cnt_next = '0;
            // A pulse at least as long as the period, or a zero period, is full duty.
            if (dividend >= divisor)
            begin
                quot_next = DUTY_ONE;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = {1'b0, dividend};
                quot_next = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? (rem_shift - {1'b0, dsr_reg}) : rem_shift;
            quot_next = {1'b0, quot_reg[DUTY_FRAC-2:0], fits};
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DUTY_FRAC - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        quot_reg <= quot_next;
    end

    assign quotient = quot_reg;
    assign status   = '{busy: busy_reg, done: done_reg};

endmodule

`default_nettype wire

// ===== sv/pwm_input_period_duty_meter_core.sv =====
`default_nettype none

// PWM input period and duty meter. Each request carries one capture of a free-running
// counter: s_tuser says whether it is a period edge (0) or a pulse edge (1). A period
// edge with a nonzero earlier capture yields a new period, scaled by the tick length,
// and a new duty in Q1.16 saturated at 1.0; a pulse edge yields a new pulse width.
// Every request returns one result with the held period, pulse width and duty, and
// m_tuser flags a fresh period. Scaling runs through a bit-serial multiplier over the
// 16 tick-length bits and the duty through a restoring divider giving one quotient bit
// per cycle. A request is accepted only in the idle state, after the previous result has
// been loaded, and a result is loaded only when the output register is empty or being
// read, so a result waiting there unread holds off the next request.
module pwm_input_period_duty_meter_core import pimd_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [TICK_WIDTH-1:0]      cfg_wdata,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [CAPTURE_WIDTH-1:0]   s_tdata,   // capture_value
    input  wire logic                       s_tuser,   // operation
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [OUT_DATA_WIDTH-1:0]       m_tdata,   // period_time, pulse_time, duty_fraction
    output logic                            m_tuser    // period_updated
);

    localparam int EW = (COUNTER_WIDTH < CAPTURE_WIDTH) ? COUNTER_WIDTH : CAPTURE_WIDTH;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                    state_reg, state_next;
    logic [TICK_WIDTH-1:0]     tick_len_reg;
    logic [EW-1:0]             cur_edge_reg;
    logic [TIME_WIDTH-1:0]     period_reg;
    logic [TIME_WIDTH-1:0]     pulse_reg;
    logic [DUTY_WIDTH-1:0]     duty_reg;
    logic                      op_reg;
    logic                      upd_reg;
    logic                      m_tvalid_reg;
    logic [OUT_DATA_WIDTH-1:0] m_tdata_reg;
    logic                      m_tuser_reg;

    logic                      accept;
    logic                      store_only;
    logic [EW-1:0]             cap;
    logic [COUNTER_WIDTH-1:0]  diff;
    logic [COUNTER_WIDTH:0]    ticks;
    logic                      mul_start;
    logic                      div_start;
    logic                      out_load;
    logic [TIME_WIDTH-1:0]     scaled_time;
    logic [DUTY_WIDTH-1:0]     quotient;
    unit_status_t              mul_status;
    unit_status_t              div_status;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign cap        = s_tdata[EW-1:0];
    assign store_only = (s_tuser == OP_PERIOD_EDGE) && (cur_edge_reg == '0);

    // Equal captures count one whole wrap of the counter.
    assign diff  = COUNTER_WIDTH'(cap) - COUNTER_WIDTH'(cur_edge_reg);
    assign ticks = {cap == cur_edge_reg, diff};

    assign mul_start = accept && !store_only;
    assign div_start = (state_reg == ST_MUL) && mul_status.done && (op_reg == OP_PERIOD_EDGE);
    assign out_load  = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    pimd_mul #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_mul (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (mul_start),
        .ticks       (ticks),
        .tick_length (tick_len_reg),
        .status      (mul_status),
        .scaled_time (scaled_time)
    );

    pimd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pulse_reg),
        .divisor  (scaled_time),
        .status   (div_status),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = store_only ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_status.done)
                begin
                    state_next = (op_reg == OP_PERIOD_EDGE) ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tick_len_reg <= TICK_LENGTH_RESET;
            cur_edge_reg <= '0;
            period_reg   <= '0;
            pulse_reg    <= '0;
            duty_reg     <= '0;
            op_reg       <= OP_PERIOD_EDGE;
            upd_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                tick_len_reg <= cfg_wdata;
            end
            if (accept)
            begin
                op_reg  <= s_tuser;
                upd_reg <= (s_tuser == OP_PERIOD_EDGE) && !store_only;
                if (s_tuser == OP_PERIOD_EDGE)
                begin
                    cur_edge_reg <= cap;
                end
            end
            if ((state_reg == ST_MUL) && mul_status.done)
            begin
                if (op_reg == OP_PERIOD_EDGE)
                begin
                    period_reg <= scaled_time;
                end
                else
                begin
                    pulse_reg <= scaled_time;
                end
            end
            if ((state_reg == ST_DIV) && div_status.done)
            begin
                duty_reg <= quotient;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= OUT_DATA_WIDTH'({duty_reg, pulse_reg, period_reg});
            m_tuser_reg <= upd_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The multiplier and the divider never run at the same time.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_status.busy && div_status.busy))
        else $error("multiplier and divider busy together");

    // A new result only appears once the sequencer has reached its final state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result issued outside the final state");

    // The duty never exceeds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2*TIME_WIDTH+DUTY_FRAC]
            |-> (m_tdata[2*TIME_WIDTH+DUTY_FRAC-1:2*TIME_WIDTH] == '0))
        else $error("duty above one");

    // Requests are taken only while no computation is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !mul_status.busy && !div_status.busy)
        else $error("request accepted while a unit is busy");

endmodule

`default_nettype wire
